>>> hdl/first_fit_block_allocator_assert.svh
// Assertion macros for the first-fit block allocator checker.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Check a property on every clock edge outside reset
`define FFBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ffba assertion failed");

// Check a property on every clock edge, reset included
`define FFBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ffba assertion failed");

`endif

>>> hdl/ffba_pkg.sv
// Shared constants and the stage item type of the first-fit block allocator.
// Used by the channel interfaces, the cell, the top level and the checker.
package ffba_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;

  // Fixed field widths of the ports
  localparam int CMD_BITS   = 1;
  localparam int IDX_BITS   = 4;
  localparam int VALUE_BITS = 16;
  localparam int CNT_BITS   = 5;

  // Cell index width and the width used to match a load index
  localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int MATCH_W = (IDX_W > IDX_BITS) ? IDX_W : IDX_BITS;

  // Command codes
  localparam logic [CMD_BITS-1:0] CMD_LOAD    = 1'b0;
  localparam logic [CMD_BITS-1:0] CMD_REQUEST = 1'b1;

  // Item as it moves from cell to cell
  typedef struct packed {
    logic                 valid;
    logic [CMD_BITS-1:0]  cmd;
    logic [IDX_BITS-1:0]  block_index;
    logic [SIZE_BITS-1:0] size;
    logic                 granted;
    logic [IDX_BITS-1:0]  block_number;
    logic [SIZE_BITS-1:0] prior;
    logic [SIZE_BITS-1:0] after;
  } stage_t;

endpackage

>>> hdl/ffba_if.sv
// Valid/ready channel interfaces for the allocator's request and result items.
// Depends on ffba_pkg for the field widths.
interface ffba_req_if;
  logic                                valid;
  logic                                ready;
  logic [ffba_pkg::CMD_BITS-1:0]       cmd;
  logic [ffba_pkg::IDX_BITS-1:0]       block_index;
  logic [ffba_pkg::VALUE_BITS-1:0]     size_value;

  modport source (output valid, cmd, block_index, size_value, input ready);
  modport sink   (input valid, cmd, block_index, size_value, output ready);
endinterface

interface ffba_res_if;
  logic                                valid;
  logic                                ready;
  logic                                granted;
  logic [ffba_pkg::IDX_BITS-1:0]       block_number;
  logic [ffba_pkg::VALUE_BITS-1:0]     size_before;
  logic [ffba_pkg::VALUE_BITS-1:0]     fragment_left;

  modport source (output valid, granted, block_number, size_before, fragment_left,
                  input ready);
  modport sink   (input valid, granted, block_number, size_before, fragment_left,
                  output ready);
endinterface

>>> hdl/ffba_cell.sv
// One allocator cell: holds the free size of one block and passes the item on.
// Depends on ffba_pkg for the stage item type and widths.
module ffba_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [ffba_pkg::IDX_W-1:0]      cell_idx,
  input  logic [ffba_pkg::CNT_BITS-1:0]   block_count,
  input  ffba_pkg::stage_t                cell_in,
  output ffba_pkg::stage_t                cell_out
);

  logic [ffba_pkg::SIZE_BITS-1:0] free_size;
  logic [ffba_pkg::SIZE_BITS-1:0] free_size_next;
  logic [ffba_pkg::SIZE_BITS-1:0] remain;
  ffba_pkg::stage_t               item_next;
  logic                           active;
  logic                           load_hit;
  logic                           fit_hit;

  // Decide whether this cell takes the load or grants the request
  always_comb begin
    active   = int'(block_count) > int'(cell_idx);
    remain   = free_size - cell_in.size;
    load_hit = cell_in.valid && (cell_in.cmd == ffba_pkg::CMD_LOAD) &&
               (ffba_pkg::MATCH_W'(cell_in.block_index) == ffba_pkg::MATCH_W'(cell_idx));
    fit_hit  = cell_in.valid && (cell_in.cmd == ffba_pkg::CMD_REQUEST) &&
               !cell_in.granted && active && (free_size >= cell_in.size);

    item_next      = cell_in;
    free_size_next = free_size;
    if (load_hit) begin
      free_size_next = cell_in.size;
    end else if (fit_hit) begin
      free_size_next         = remain;
      item_next.granted      = 1'b1;
      item_next.block_number = ffba_pkg::IDX_BITS'(cell_idx);
      item_next.prior        = free_size;
      item_next.after        = remain;
    end
  end

  // Hold the block size and advance the item with the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      free_size      <= '0;
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      free_size <= free_size_next;
      cell_out  <= item_next;
    end
  end

endmodule

>>> hdl/first_fit_block_allocator.sv
// First-fit block allocator: a chain of NUM_BLOCKS cells, one block each.
// An accepted item passes through the NUM_BLOCKS cell registers, then the result register.
// Throughput: one item per cycle while results are taken; the chain stalls as one.
// Reset clears every block size, the block count and all valid flags at once.
module first_fit_block_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ffba_pkg::CNT_BITS-1:0]   cfg_data,
  ffba_req_if.sink                        req,
  ffba_res_if.source                      res
);

  logic [ffba_pkg::CNT_BITS-1:0] block_count;
  logic                          advance;
  logic                          res_valid;
  ffba_pkg::stage_t              res_item;
  ffba_pkg::stage_t              stage [ffba_pkg::NUM_BLOCKS+1];

  // Move the whole chain when the result register is free or being taken
  assign advance   = !res_valid || res.ready;
  assign req.ready = advance;

  // Build the item entering the first cell
  always_comb begin
    stage[0]              = '0;
    stage[0].valid        = req.valid;
    stage[0].cmd          = req.cmd;
    stage[0].block_index  = req.block_index;
    stage[0].size         = ffba_pkg::SIZE_BITS'(req.size_value);
  end

  // Hold the block count register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
    end else if (cfg_we) begin
      block_count <= cfg_data;
    end
  end

  // Chain of block cells
  for (genvar k = 0; k < ffba_pkg::NUM_BLOCKS; k++) begin : g_cell
    ffba_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .cell_idx    (ffba_pkg::IDX_W'(k)),
      .block_count (block_count),
      .cell_in     (stage[k]),
      .cell_out    (stage[k+1])
    );
  end

  // Capture the finished item into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage[ffba_pkg::NUM_BLOCKS].valid;
      res_item  <= stage[ffba_pkg::NUM_BLOCKS];
    end
  end

  assign res.valid         = res_valid;
  assign res.granted       = res_item.granted;
  assign res.block_number  = res_item.block_number;
  assign res.size_before   = ffba_pkg::VALUE_BITS'(res_item.prior);
  assign res.fragment_left = ffba_pkg::VALUE_BITS'(res_item.after);

endmodule

>>> hdl/ffba_checker.sv
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and the assertion macros in first_fit_block_allocator_assert.svh.
`include "first_fit_block_allocator_assert.svh"

module ffba_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              res_valid,
  input logic                              res_ready,
  input logic                              granted,
  input logic [ffba_pkg::IDX_BITS-1:0]     block_number,
  input logic [ffba_pkg::VALUE_BITS-1:0]   size_before,
  input logic [ffba_pkg::VALUE_BITS-1:0]   fragment_left
);

  // A stalled result stays offered
  `FFBA_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid)

  // A stalled result keeps its payload
  `FFBA_ASSERT(a_res_stable, res_valid && !res_ready |=> $stable({granted, block_number, size_before, fragment_left}))

  // A result without a grant carries all-zero fields
  `FFBA_ASSERT(a_nogrant_zero, res_valid && !granted |-> block_number == '0 && size_before == '0 && fragment_left == '0)

  // A grant never leaves more than the block held before
  `FFBA_ASSERT(a_grant_shrinks, res_valid && granted |-> fragment_left <= size_before)

  // No result right after reset
  `FFBA_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !res_valid)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .granted       (res.granted),
  .block_number  (res.block_number),
  .size_before   (res.size_before),
  .fragment_left (res.fragment_left)
);

>>> tb/first_fit_block_allocator_checker.sv
// Scoreboard for the first-fit block allocator: keeps its own block table,
// predicts one result per accepted item and compares the results in order.
// Depends on ffba_pkg and the channel interfaces in ffba_if.
module first_fit_block_allocator_checker
  import ffba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_BITS-1:0] cfg_data,
  ffba_req_if                 req,
  ffba_res_if                 res,
  output int                  fail_count,
  output int                  pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  granted;
    logic [IDX_BITS-1:0]   block_number;
    logic [VALUE_BITS-1:0] size_before;
    logic [VALUE_BITS-1:0] fragment_left;
  } grant_t;

  logic [SIZE_BITS-1:0] free_space [NUM_BLOCKS];
  logic [CNT_BITS-1:0]  search_count;
  grant_t               expected_grants [$];

  // Apply one item to the shadow table and return the result it must produce
  function automatic grant_t place_first_fit(input logic [CMD_BITS-1:0]   op,
                                             input logic [IDX_BITS-1:0]   idx,
                                             input logic [VALUE_BITS-1:0] amount);
    grant_t               outcome;
    logic [SIZE_BITS-1:0] need;
    int                   span;
    int                   k;
    outcome = '0;
    need = amount;
    if (op == CMD_LOAD) begin
      if (int'(idx) < NUM_BLOCKS) free_space[idx] = need;
      return outcome;
    end
    // Search saturates at the table size
    span = (int'(search_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(search_count);
    for (k = 0; k < span; k++) begin
      if (free_space[k] >= need) begin
        outcome.granted       = 1'b1;
        outcome.block_number  = IDX_BITS'(k);
        outcome.size_before   = VALUE_BITS'(free_space[k]);
        free_space[k]         = free_space[k] - need;
        outcome.fragment_left = VALUE_BITS'(free_space[k]);
        break;
      end
    end
    return outcome;
  endfunction

  task automatic report_failure(input string msg);
    $display("[%0t] %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      // Clear the shadow state
      for (int b = 0; b < NUM_BLOCKS; b++) free_space[b] = '0;
      search_count = '0;
      expected_grants.delete();
    end else begin
      if (cfg_we) search_count = cfg_data;
      // Predict each accepted item
      if (req.valid && req.ready)
        expected_grants.push_back(place_first_fit(req.cmd, req.block_index, req.size_value));
      // Compare each accepted result against the oldest prediction
      if (res.valid && res.ready) begin
        if (expected_grants.size() == 0) begin
          report_failure("result item arrived with nothing outstanding");
        end else begin
          want = expected_grants.pop_front();
          if (res.granted !== want.granted)
            report_failure($sformatf("granted: got %0b, expected %0b",
                                     res.granted, want.granted));
          if (res.block_number !== want.block_number)
            report_failure($sformatf("block_number: got %0d, expected %0d",
                                     res.block_number, want.block_number));
          if (res.size_before !== want.size_before)
            report_failure($sformatf("size_before: got 0x%0h, expected 0x%0h",
                                     res.size_before, want.size_before));
          if (res.fragment_left !== want.fragment_left)
            report_failure($sformatf("fragment_left: got 0x%0h, expected 0x%0h",
                                     res.fragment_left, want.fragment_left));
        end
      end
    end
    pending_results <= expected_grants.size();
  end

endmodule

>>> tb/first_fit_block_allocator_tb.sv
// Top of the first-fit block allocator testbench: clock, reset, stimulus and verdict.
// Depends on ffba_pkg, ffba_if, the allocator RTL and first_fit_block_allocator_checker.
module first_fit_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffba_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 58;
  localparam int REFILL_ITEMS = 8;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CNT_BITS-1:0] cfg_data;
  int                  send_gap_pct;
  int                  recv_stall_pct;
  int                  fail_count;
  int                  pending_results;
  int                  cycles;

  ffba_req_if req_ch ();
  ffba_res_if res_ch ();

  first_fit_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  first_fit_block_allocator_checker scoreboard (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .req             (req_ch),
    .res             (res_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result side at random
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one item, with random gaps first, and hold it until accepted
  task automatic issue_command(input logic [CMD_BITS-1:0]   op,
                               input logic [IDX_BITS-1:0]   idx,
                               input logic [VALUE_BITS-1:0] amount);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= op;
    req_ch.block_index <= idx;
    req_ch.size_value  <= amount;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic set_block_count(input logic [CNT_BITS-1:0] count);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mix of loads and requests, biased toward sizes that tend to fit
  task automatic issue_random_command();
    logic [VALUE_BITS-1:0] amount;
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(9))
        0:       amount = '0;
        1:       amount = '1;
        default: amount = VALUE_BITS'($urandom);
      endcase
      issue_command(CMD_LOAD, IDX_BITS'($urandom), amount);
    end else begin
      case ($urandom_range(9))
        0:       amount = '0;
        1:       amount = '1;
        2, 3, 4: amount = VALUE_BITS'($urandom_range(0, 255));
        default: amount = VALUE_BITS'($urandom);
      endcase
      issue_command(CMD_REQUEST, IDX_BITS'($urandom), amount);
    end
  endtask

  initial begin
    logic [CNT_BITS-1:0] count;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_LOAD;
    req_ch.block_index <= '0;
    req_ch.size_value  <= '0;
    send_gap_pct   = 8;
    recv_stall_pct = 48;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: block count still zero after reset, nothing fits
    issue_command(CMD_REQUEST, 4'd0, 16'd0);
    // Load outside the search range still lands
    issue_command(CMD_LOAD, 4'd3, 16'd100);
    issue_command(CMD_REQUEST, 4'd0, 16'd5);

    set_block_count(5'd16);
    issue_command(CMD_REQUEST, 4'd15, 16'd5);
    // Zero-size request fits an empty first block and leaves it as is
    issue_command(CMD_LOAD, 4'd0, 16'd0);
    issue_command(CMD_REQUEST, 4'd0, 16'd0);
    // Full-size block taken whole, then no room left
    issue_command(CMD_LOAD, 4'd15, 16'hFFFF);
    issue_command(CMD_REQUEST, 4'd0, 16'hFFFF);
    issue_command(CMD_REQUEST, 4'd0, 16'hFFFF);
    issue_command(CMD_LOAD, 4'd7, 16'hFFFF);
    issue_command(CMD_REQUEST, 4'd0, 16'h8000);
    issue_command(CMD_REQUEST, 4'd0, 16'd95);
    issue_command(CMD_REQUEST, 4'd0, 16'h7FFF);
    issue_command(CMD_REQUEST, 4'd0, 16'd1);

    // Count above the table size saturates
    set_block_count(5'd31);
    issue_command(CMD_LOAD, 4'd15, 16'd10);
    issue_command(CMD_REQUEST, 4'd0, 16'd10);

    // Narrow searches
    set_block_count(5'd1);
    issue_command(CMD_LOAD, 4'd1, 16'd50);
    issue_command(CMD_REQUEST, 4'd0, 16'd20);
    issue_command(CMD_REQUEST, 4'd0, 16'd0);
    set_block_count(5'd2);
    issue_command(CMD_REQUEST, 4'd0, 16'd20);

    // Random phases: three idling patterns, several block counts each
    for (int mode = 0; mode < 3; mode++) begin
      drain_results();
      case (mode)
        0: begin
          send_gap_pct   = 8;
          recv_stall_pct = 48;
        end
        1: begin
          send_gap_pct   = 48;
          recv_stall_pct = 8;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int sub = 0; sub < 6; sub++) begin
        case (sub)
          0:       count = 5'd16;
          1:       count = CNT_BITS'($urandom_range(2, 15));
          2:       count = (mode == 1) ? 5'd17 : 5'd31;
          3:       count = 5'd1;
          4:       count = CNT_BITS'($urandom_range(0, 31));
          default: count = (mode == 2) ? 5'd0 : CNT_BITS'($urandom_range(8, 16));
        endcase
        set_block_count(count);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          // Refill the table at the start of each phase
          if (n < REFILL_ITEMS)
            issue_command(CMD_LOAD, IDX_BITS'($urandom), VALUE_BITS'($urandom));
          else
            issue_random_command();
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
